// File: rtl/bads_pkg.sv
// ----------------------------------------------------------------------------
// Box average downscaler package
// Widths, limits and shared constants of the downscaler and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package bads_pkg;

   localparam int PIX_W          = 24;
   localparam int GRAY_W         = 8;
   localparam int MAX_WIDTH      = 4096;
   localparam int COL_W          = 12;
   localparam int WIDTH_W        = 13;
   localparam int ROW_W          = 16;
   localparam int RATE_W         = 17;
   localparam int PROD_W         = ROW_W + RATE_W;
   localparam int CNT_W          = 9;
   localparam int SUM_W          = 17;
   localparam int MAX_BLOCK_ROWS = 257;
   localparam int PASS_RATE      = 65530;
   localparam int MIN_RATE       = 256;
   localparam int GRAY_MAX       = 255;

   // shared divider: 24-bit dividend, 9-bit divisor, one bit per cycle
   localparam int DIV_W      = 24;
   localparam int DIV_STEP_W = 5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

endpackage

`default_nettype wire

// File: rtl/bads_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bads_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/bads_div.sv
// ----------------------------------------------------------------------------
// Saturating radix-2 divider
// Restoring division, one quotient bit per cycle; quotient clipped to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module bads_div
   import bads_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_W-1:0]    num,
   input  wire logic [CNT_W-1:0]    den,
   output logic                     done,
   output logic      [GRAY_W-1:0]   quot
);

   logic                  busy_ff,  busy_in;
   logic                  done_ff,  done_in;
   logic [DIV_STEP_W-1:0] step_ff,  step_in;
   logic [DIV_W-1:0]      acc_ff,   acc_in;
   logic [CNT_W-1:0]      rem_ff,   rem_in;
   logic [CNT_W-1:0]      den_ff,   den_in;
   logic [GRAY_W-1:0]     quot_ff,  quot_in;
   logic [CNT_W:0]        trial;
   logic                  fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, acc_ff[DIV_W-1]};
      fits    = trial >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_W'(DIV_W);
         acc_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when the divisor fits
         rem_in  = fits ? CNT_W'(trial - {1'b0, den_ff}) : trial[CNT_W-1:0];
         acc_in  = {acc_ff[DIV_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = (|acc_in[DIV_W-1:GRAY_W]) ? GRAY_W'(GRAY_MAX) : acc_in[GRAY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// File: rtl/box_average_image_downscaler_top.sv
// A pass-through pixel goes from IDLE straight to FIN; any other pixel runs MULR, MULC and UPD,
// an RGB pixel that closes a block adds HSUM, a gray one adds DIV1 and HSUM, and a gray pixel
// that closes a column group adds DIV2 too. One pixel at a time; the two 24-step divisions of
// the shared divider set the worst case. The output register holds a result while the next
// pixel is taken. Reset (synchronous, active high) clears counters, control and configuration
// registers to their defaults; the column memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Box average image downscaler
// Raster-order pixel stream in, area-averaged (gray) or decimated (RGB) out.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_image_downscaler_top
   import bads_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIX_W-1:0]      req_tdata,   // [23:0] pixel_in
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [PIX_W-1:0]      rsp_tdata,   // [23:0] pixel_out
   output logic                       rsp_tlast,   // row_end
   output logic                       rsp_tuser,   // [0] image_end
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RGB    = 2'd3;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MULR = 3'd1;
   localparam logic [2:0] S_MULC = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_DIV1 = 3'd4;
   localparam logic [2:0] S_HSUM = 3'd5;
   localparam logic [2:0] S_DIV2 = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   // configuration
   logic [WIDTH_W-1:0] width_ff;
   logic [ROW_W-1:0]   height_ff;
   logic [RATE_W-1:0]  rate_cfg_ff;
   logic               rgb_ff;

   // sequencer and block state
   logic [2:0]        state_ff,    state_in;
   logic [CNT_W-1:0]  brc_ff,      brc_in;
   logic [ROW_W-1:0]  dest_row_ff, dest_row_in;
   logic [ROW_W-1:0]  src_row_ff,  src_row_in;
   logic [COL_W-1:0]  src_col_ff,  src_col_in;
   logic [COL_W-1:0]  dest_col_ff, dest_col_in;
   logic [SUM_W-1:0]  hsum_ff,     hsum_in;
   logic [CNT_W-1:0]  hcnt_ff,     hcnt_in;

   // per-pixel working registers
   logic [PIX_W-1:0]  pix_ff,       pix_in;
   logic [RATE_W-1:0] rate_ff,      rate_in;
   logic              lastc_ff,     lastc_in;
   logic              lastr_ff,     lastr_in;
   logic              pass_ff,      pass_in;
   logic              rowclose_ff,  rowclose_in;
   logic              emit_ff,      emit_in;
   logic [ROW_W-1:0]  row_floor_ff, row_floor_in;
   logic [COL_W-1:0]  ncol_ff,      ncol_in;
   logic [CNT_W-1:0]  cnt_ff,       cnt_in;
   logic [PIX_W-1:0]  colval_ff,    colval_in;
   logic [PIX_W-1:0]  result_ff,    result_in;
   logic [PROD_W-1:0] prod_ff;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  out_data_ff,  out_data_in;
   logic              out_last_ff,  out_last_in;
   logic              out_user_ff,  out_user_in;

   logic [WIDTH_W-1:0] width_eff;
   logic [ROW_W-1:0]   height_eff;
   logic               lastc_now;
   logic               lastr_now;
   logic               take;
   logic [ROW_W-1:0]   mul_a;
   logic [PIX_W-1:0]   col_new;
   logic               ram_we;
   logic [PIX_W-1:0]   ram_rdata;
   logic               div_start;
   logic [DIV_W-1:0]   div_num;
   logic [CNT_W-1:0]   div_den;
   logic               div_done;
   logic [GRAY_W-1:0]  div_quot;
   logic [CNT_W-1:0]   hcnt_new;
   logic [SUM_W-1:0]   hsum_new;
   logic               out_free;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_W'(1);
         height_ff   <= ROW_W'(1);
         rate_cfg_ff <= RATE_W'(65536);
         rgb_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WIDTH:  width_ff    <= csr_data[WIDTH_W-1:0];
            REG_HEIGHT: height_ff   <= csr_data[ROW_W-1:0];
            REG_RATE:   rate_cfg_ff <= csr_data[RATE_W-1:0];
            REG_RGB:    rgb_ff      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         width_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;
      lastc_now  = ({1'b0, src_col_ff} + WIDTH_W'(1)) >= width_eff;
      lastr_now  = ({1'b0, src_row_ff} + (ROW_W+1)'(1)) >= {1'b0, height_eff};
   end

   // shared multiplier: row index first, then column index
   assign mul_a = (state_ff == S_MULR) ? src_row_ff : ROW_W'(src_col_ff);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(rate_ff);
   end

   bads_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_col_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (src_col_ff),
      .wr_data (col_new),
      .rd_addr (src_col_ff),
      .rd_data (ram_rdata)
   );

   bads_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      if (brc_ff == '0) begin
         col_new = rgb_ff ? pix_ff : PIX_W'(pix_ff[GRAY_W-1:0]);
      end else if (!rgb_ff) begin
         col_new = ram_rdata + PIX_W'(pix_ff[GRAY_W-1:0]);
      end else begin
         col_new = ram_rdata;
      end
      ram_we   = (state_ff == S_UPD) && ((brc_ff == '0) || !rgb_ff);
      hcnt_new = (hcnt_ff < CNT_W'(MAX_BLOCK_ROWS)) ? hcnt_ff + 1'b1 : hcnt_ff;
      hsum_new = rgb_ff ? hsum_ff : hsum_ff + SUM_W'(colval_ff[GRAY_W-1:0]);
      out_free = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in     = state_ff;
      brc_in       = brc_ff;
      dest_row_in  = dest_row_ff;
      src_row_in   = src_row_ff;
      src_col_in   = src_col_ff;
      dest_col_in  = dest_col_ff;
      hsum_in      = hsum_ff;
      hcnt_in      = hcnt_ff;
      pix_in       = pix_ff;
      rate_in      = rate_ff;
      lastc_in     = lastc_ff;
      lastr_in     = lastr_ff;
      pass_in      = pass_ff;
      rowclose_in  = rowclose_ff;
      emit_in      = emit_ff;
      row_floor_in = row_floor_ff;
      ncol_in      = ncol_ff;
      cnt_in       = cnt_ff;
      colval_in    = colval_ff;
      result_in    = result_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      div_start    = 1'b0;
      div_num      = PIX_W'(hsum_new);
      div_den      = hcnt_new;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               pix_in      = req_tdata;
               lastc_in    = lastc_now;
               lastr_in    = lastr_now;
               pass_in     = rate_cfg_ff >= RATE_W'(PASS_RATE);
               rate_in     = (rate_cfg_ff < RATE_W'(MIN_RATE)) ? RATE_W'(MIN_RATE)
                                                               : rate_cfg_ff;
               rowclose_in = 1'b0;
               result_in   = req_tdata;
               if (rate_cfg_ff >= RATE_W'(PASS_RATE)) begin
                  emit_in  = 1'b1;
                  state_in = S_FIN;
               end else begin
                  emit_in  = 1'b0;
                  state_in = S_MULR;
               end
            end
         end
         S_MULR: begin
            state_in = S_MULC;
         end
         S_MULC: begin
            row_floor_in = prod_ff[ROW_W+15:16];
            rowclose_in  = (prod_ff[ROW_W+15:16] != dest_row_ff) || lastr_ff;
            state_in     = S_UPD;
         end
         S_UPD: begin
            ncol_in   = prod_ff[COL_W+15:16];
            cnt_in    = (brc_ff < CNT_W'(MAX_BLOCK_ROWS)) ? brc_ff + 1'b1 : brc_ff;
            colval_in = col_new;
            if (!rowclose_ff) begin
               state_in = S_FIN;
            end else if (rgb_ff) begin
               state_in = S_HSUM;
            end else begin
               div_start = 1'b1;
               div_num   = col_new;
               div_den   = (brc_ff < CNT_W'(MAX_BLOCK_ROWS)) ? brc_ff + 1'b1 : brc_ff;
               state_in  = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               colval_in = PIX_W'(div_quot);
               state_in  = S_HSUM;
            end
         end
         S_HSUM: begin
            hcnt_in   = hcnt_new;
            hsum_in   = hsum_new;
            emit_in   = (ncol_ff != dest_col_ff) || lastc_ff;
            result_in = colval_ff;
            if ((ncol_ff != dest_col_ff || lastc_ff) && !rgb_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV2;
            end else begin
               state_in  = S_FIN;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               result_in = PIX_W'(div_quot);
               state_in  = S_FIN;
            end
         end
         S_FIN: begin
            // when a word is due, hold until the output register can take it
            if (!emit_ff || out_free) begin
               if (emit_ff) begin
                  out_valid_in = 1'b1;
                  out_data_in  = result_ff;
                  out_last_in  = lastc_ff;
                  out_user_in  = lastc_ff && lastr_ff;
               end
               if (pass_ff) begin
                  brc_in      = '0;
                  dest_row_in = '0;
                  dest_col_in = '0;
                  hsum_in     = '0;
                  hcnt_in     = '0;
               end else if (emit_ff) begin
                  hsum_in     = '0;
                  hcnt_in     = '0;
                  dest_col_in = ncol_ff;
               end
               if (lastc_ff) begin
                  src_col_in  = '0;
                  dest_col_in = '0;
                  hsum_in     = '0;
                  hcnt_in     = '0;
                  if (!pass_ff) begin
                     if (rowclose_ff) begin
                        brc_in      = '0;
                        dest_row_in = row_floor_ff;
                     end else begin
                        brc_in      = cnt_ff;
                     end
                  end
                  if (lastr_ff) begin
                     src_row_in  = '0;
                     dest_row_in = '0;
                     brc_in      = '0;
                  end else begin
                     src_row_in  = src_row_ff + 1'b1;
                  end
               end else begin
                  src_col_in = src_col_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         brc_ff       <= '0;
         dest_row_ff  <= '0;
         src_row_ff   <= '0;
         src_col_ff   <= '0;
         dest_col_ff  <= '0;
         hsum_ff      <= '0;
         hcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
         emit_ff      <= 1'b0;
         pass_ff      <= 1'b0;
         rowclose_ff  <= 1'b0;
         lastc_ff     <= 1'b0;
         lastr_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         brc_ff       <= brc_in;
         dest_row_ff  <= dest_row_in;
         src_row_ff   <= src_row_in;
         src_col_ff   <= src_col_in;
         dest_col_ff  <= dest_col_in;
         hsum_ff      <= hsum_in;
         hcnt_ff      <= hcnt_in;
         out_valid_ff <= out_valid_in;
         emit_ff      <= emit_in;
         pass_ff      <= pass_in;
         rowclose_ff  <= rowclose_in;
         lastc_ff     <= lastc_in;
         lastr_ff     <= lastr_in;
      end
      pix_ff       <= pix_in;
      rate_ff      <= rate_in;
      row_floor_ff <= row_floor_in;
      ncol_ff      <= ncol_in;
      cnt_ff       <= cnt_in;
      colval_ff    <= colval_in;
      result_ff    <= result_in;
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      out_user_ff  <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef SYNTH
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a pixel is in flight");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divider finished outside a divide wait");

   a_row_count_sat: assert property (@(posedge clock) disable iff (reset)
      brc_ff <= CNT_W'(MAX_BLOCK_ROWS) && hcnt_ff <= CNT_W'(MAX_BLOCK_ROWS))
      else $error("block count beyond saturation limit");

   a_image_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("image end without row end");
`endif

endmodule

`default_nettype wire

// File: tb/tb_box_average_image_downscaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box average image downscaler testbench
// Streams raster pixels through the downscaler under many register settings
// (gray averaging, RGB decimation, pass-through, clamped geometry and rate,
// mid-image geometry shrink, count saturation) and checks every output word
// against a cycle-free predictor of the scaled image, with random stalls on
// both streams.
// ----------------------------------------------------------------------------

module tb_box_average_image_downscaler_top;
   import bads_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 550;
   localparam int unsigned DRAIN_CYCLES   = 100;
   localparam int unsigned LONG_CHOKE     = 400;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned MAX_REPORTS    = 40;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_SCALE_RATE = 2'd2,
      REG_RGB_MODE   = 2'd3
   } csr_reg_e;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
      logic             image_end;
   } scaled_pixel_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   box_average_image_downscaler_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copy and downscaler state of the predictor
   logic [WIDTH_W-1:0] cfg_width  = 13'd1;
   logic [ROW_W-1:0]   cfg_height = 16'd1;
   logic [RATE_W-1:0]  cfg_rate   = 17'd65536;
   logic               cfg_rgb    = 1'b0;

   logic [PIX_W-1:0]   col_mem [0:MAX_WIDTH-1];
   logic [CNT_W-1:0]   blk_rows  = '0;
   logic [CNT_W-1:0]   grp_cols  = '0;
   logic [ROW_W-1:0]   in_row    = '0;
   logic [ROW_W-1:0]   out_row   = '0;
   logic [COL_W-1:0]   in_col    = '0;
   logic [COL_W-1:0]   out_col   = '0;
   logic [SUM_W-1:0]   grp_sum   = '0;

   logic [PIX_W-1:0]   pending_pixels [$];
   scaled_pixel_t      scaled_pixels_due [$];
   scaled_pixel_t      head_pixel;

   int unsigned pixels_queued   = 0;
   int unsigned pixels_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned settings        = 0;
   int unsigned mismatches      = 0;
   int unsigned gap_left        = 0;
   int unsigned stall_left      = 0;
   int unsigned quiet_cycles    = 0;
   int unsigned choke_req       = 0;
   int unsigned choke_seen      = 0;
   logic        req_gaps_on     = 1'b1;
   logic        rsp_gaps_on     = 1'b1;

   function automatic int unsigned scale_index(input int unsigned pos,
                                               input int unsigned rate);
      longint unsigned prod;
      prod = pos;
      prod = prod * rate;
      return int'(prod >> 16);
   endfunction

   function automatic int unsigned sat_quotient(input int unsigned num,
                                                input int unsigned den);
      int unsigned q;
      q = (den == 0) ? 0 : num / den;
      return (q > GRAY_MAX) ? GRAY_MAX : q;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PIX_W-1:0] any_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return {16'($urandom), 8'($urandom_range(240, 255))};
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [PIX_W-1:0] want,
                                  input logic [PIX_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // advance the predictor by one source pixel, queue the scaled pixel it closes
   task automatic downscale_pixel(input logic [PIX_W-1:0] pix);
      int unsigned   w, h, rate, cnt, colval, ncol;
      bit            last_col, last_row, closes;
      scaled_pixel_t res;
      w = (cfg_width == 0) ? 1 : cfg_width;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (cfg_height == 0) ? 1 : cfg_height;
      rate = cfg_rate;
      last_col = (int'(in_col) + 1 >= w);
      last_row = (int'(in_row) + 1 >= h);

      if (rate >= PASS_RATE) begin
         res.pixel = pix;
         res.row_end = last_col;
         res.image_end = last_col && last_row;
         scaled_pixels_due.push_back(res);
         blk_rows = '0;
         out_row = '0;
         out_col = '0;
         grp_sum = '0;
         grp_cols = '0;
         if (last_col) begin
            in_col = '0;
            in_row = last_row ? '0 : in_row + 1'b1;
         end else begin
            in_col = in_col + 1'b1;
         end
         return;
      end
      if (rate < MIN_RATE) rate = MIN_RATE;

      closes = (scale_index(in_row, rate) != out_row) || last_row;
      cnt = blk_rows + 1;
      if (cnt > MAX_BLOCK_ROWS) cnt = MAX_BLOCK_ROWS;

      // first row of a block loads the column, later gray rows accumulate
      if (blk_rows == 0)
         col_mem[in_col] = cfg_rgb ? pix : {16'd0, pix[GRAY_W-1:0]};
      else if (!cfg_rgb)
         col_mem[in_col] = col_mem[in_col] + pix[GRAY_W-1:0];

      if (closes) begin
         colval = cfg_rgb ? col_mem[in_col] : sat_quotient(col_mem[in_col], cnt);
         ncol = scale_index(in_col, rate);
         if (grp_cols < MAX_BLOCK_ROWS) grp_cols = grp_cols + 1'b1;
         if (!cfg_rgb) grp_sum = SUM_W'(grp_sum + colval);
         if (ncol != out_col || last_col) begin
            res.pixel = cfg_rgb ? PIX_W'(colval) : PIX_W'(sat_quotient(grp_sum, grp_cols));
            res.row_end = last_col;
            res.image_end = last_col && last_row;
            scaled_pixels_due.push_back(res);
            grp_sum = '0;
            grp_cols = '0;
            out_col = COL_W'(ncol);
         end
      end

      if (last_col) begin
         in_col = '0;
         out_col = '0;
         grp_sum = '0;
         grp_cols = '0;
         if (closes) begin
            blk_rows = '0;
            out_row = ROW_W'(scale_index(in_row, rate));
         end else begin
            blk_rows = CNT_W'(cnt);
         end
         if (last_row) begin
            in_row = '0;
            out_row = '0;
            blk_rows = '0;
         end else begin
            in_row = in_row + 1'b1;
         end
      end else begin
         in_col = in_col + 1'b1;
      end
   endtask

   // source pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pixels_accepted++;
            downscale_pixel(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               req_tvalid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_pixels.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_pixels.pop_front();
               gap_left <= req_gaps_on ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result backpressure: random stalls plus an occasional long choke
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         choke_seen <= 0;
      end else if (choke_seen != choke_req) begin
         choke_seen <= choke_req;
         rsp_tready <= 1'b0;
         stall_left <= LONG_CHOKE;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_gaps_on && $urandom_range(0, 99) < 25) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (scaled_pixels_due.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_tdata);
         end else begin
            head_pixel = scaled_pixels_due.pop_front();
            results_checked++;
            if (rsp_tdata !== head_pixel.pixel)
               report_mismatch("pixel_out", head_pixel.pixel, rsp_tdata);
            if (rsp_tlast !== head_pixel.row_end)
               report_mismatch("row_end", PIX_W'(head_pixel.row_end), PIX_W'(rsp_tlast));
            if (rsp_tuser !== head_pixel.image_end)
               report_mismatch("image_end", PIX_W'(head_pixel.image_end), PIX_W'(rsp_tuser));
         end
      end
   end

   // end the run if no word moves on any channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[%0t] no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("box_average_image_downscaler_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input csr_reg_e idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SRC_WIDTH:  cfg_width = WIDTH_W'(value);
         REG_SRC_HEIGHT: cfg_height = ROW_W'(value);
         REG_SCALE_RATE: cfg_rate = RATE_W'(value);
         REG_RGB_MODE:   cfg_rgb = value[0];
         default: ;
      endcase
   endtask

   task automatic set_mode(input int unsigned w, input int unsigned h,
                           input int unsigned rate, input bit rgb);
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
      write_reg(REG_SCALE_RATE, rate);
      write_reg(REG_RGB_MODE, rgb);
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic queue_pixel(input logic [PIX_W-1:0] pix);
      pending_pixels.push_back(pix);
      pixels_queued++;
   endtask

   task automatic queue_pixels(input int unsigned n, input bit bright);
      repeat (n) begin
         if (bright)
            queue_pixel({16'($urandom), 8'($urandom_range(200, 255))});
         else
            queue_pixel(any_pixel());
      end
   endtask

   // hold until every pixel is taken and every scaled pixel is out,
   // then let pixels that close nothing finish inside the block
   task automatic settle();
      while (pixels_accepted != pixels_queued || scaled_pixels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic shuffle_idling();
      req_gaps_on <= ($urandom_range(0, 3) != 0);
      rsp_gaps_on <= ($urandom_range(0, 3) != 0);
   endtask

   function automatic int unsigned pick_rate();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return $urandom_range(PASS_RATE, 65536);
      if (roll < 20) return $urandom_range(65537, 131071);
      if (roll < 25) return $urandom_range(0, MIN_RATE);
      if (roll < 30) return PASS_RATE - 1;
      if (roll < 40) return $urandom_range(MIN_RATE, 8191);
      return $urandom_range(8192, PASS_RATE - 1);
   endfunction

   initial begin
      int unsigned w, h, ew, eh, nw, nh, rate, n, cols_left, rows_after;
      int unsigned random_items;
      bit          rgb;
      random_items = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 1x1 pass-through, every pixel ends an image
      queue_pixel(24'h000000);
      queue_pixel(24'hFFFFFF);
      settle();

      // gray 2:1 box over a 4x2 image
      set_mode(4, 2, 32768, 0);
      queue_pixel(24'h0000FF);
      queue_pixel(24'h000000);
      queue_pixel(24'hFFFFFF);
      queue_pixel(24'h000001);
      queue_pixel(24'h0000FE);
      queue_pixel(24'h0000FF);
      queue_pixel(24'hAAAAAA);
      queue_pixel(24'h555555);
      settle();

      // RGB decimation
      set_mode(3, 3, 32768, 1);
      queue_pixels(9, 0);
      settle();

      // just below the pass-through threshold
      set_mode(3, 1, PASS_RATE - 1, 0);
      queue_pixels(3, 0);
      settle();

      // zero width and height act as one, rate under the floor is clamped
      set_mode(0, 0, 100, 0);
      queue_pixels(2, 0);
      settle();

      // tallest image, cut short by shrinking both width and height mid-image
      set_mode(6, 65535, 40000, 0);
      queue_pixels(20, 0);
      settle();
      set_mode(2, 2, 40000, 0);
      queue_pixels(1, 0);
      settle();

      // stretch one vertical block past the row count limit: rate 512 then 256
      set_mode(1, 1000, 512, 0);
      queue_pixels(256, 1);
      settle();
      set_mode(1, 1000, 256, 0);
      queue_pixels(257, 1);
      settle();
      set_mode(1, 1, 256, 0);
      queue_pixels(1, 1);
      settle();

      // same trick across one row for the column count
      set_mode(600, 1, 512, 0);
      queue_pixels(256, 1);
      settle();
      set_mode(600, 1, 256, 0);
      queue_pixels(344, 1);
      settle();

      // oversize width clamps to the widest row; choke the result side meanwhile
      set_mode(8191, 1, 65536, 0);
      choke_req <= choke_req + 1;
      queue_pixels(MAX_WIDTH, 0);
      settle();

      // widest row in RGB at the smallest rate
      set_mode(MAX_WIDTH, 1, MIN_RATE, 1);
      queue_pixels(MAX_WIDTH, 0);
      settle();

      // random whole images, with some cut short by a geometry shrink
      while (random_items < RANDOM_ITEMS) begin
         n = $urandom_range(0, 99);
         if (n < 10) begin
            w = $urandom_range(0, 1);
         end else if (n < 80) begin
            w = $urandom_range(2, 24);
         end else begin
            w = $urandom_range(25, 96);
         end
         if (w > 24)
            h = $urandom_range(1, 3);
         else if ($urandom_range(0, 19) == 0)
            h = 0;
         else
            h = $urandom_range(1, 12);
         ew = (w == 0) ? 1 : w;
         eh = (h == 0) ? 1 : h;
         rate = pick_rate();
         rgb = $urandom_range(0, 1);
         shuffle_idling();
         set_mode(w, h, rate, rgb);

         if ($urandom_range(0, 99) < 15 && ew * eh > 1) begin
            n = $urandom_range(1, ew * eh - 1);
            queue_pixels(n, 0);
            random_items += n;
            settle();
            nw = $urandom_range(1, ew);
            nh = $urandom_range(1, eh);
            set_mode(nw, nh, rate, rgb);
            // pixels left until the shrunk image ends
            cols_left = (int'(in_col) + 1 >= nw) ? 1 : nw - in_col;
            rows_after = (int'(in_row) + 1 >= nh) ? 0 : nh - 1 - in_row;
            n = cols_left + rows_after * nw;
         end else begin
            n = $urandom_range(1, 2) * ew * eh;
         end
         queue_pixels(n, 0);
         random_items += n;
         settle();
      end

      $display("Streamed %0d source pixels and checked %0d scaled pixels over %0d settings,",
               pixels_accepted, results_checked, settings);
      $display("covering gray, RGB, pass-through, clamped geometry, shrink and saturation.");
      if (mismatches == 0) begin
         $display("box_average_image_downscaler_top verification clean");
      end else begin
         $display("box_average_image_downscaler_top verification failed");
      end
      $finish;
   end

endmodule
